// ===== design/uvst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere tessellator package
// Shared types and fixed constants: divider sizing, the fixed-point sine
// series constants and the vertex record that leaves the core.
// ----------------------------------------------------------------------------
package uvst_pkg;

  localparam int DIV_W  = 44;
  localparam int DIVR_W = 12;

  localparam logic [30:0] Q30_ONE      = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // Reciprocals ceil(2^(32+L)/d) with 2^(L-1) < d <= 2^L give an exact floor
  // division for every 32-bit dividend.
  localparam logic [32:0] TAYLOR_RECIP [6] = '{
    33'(((64'd1 << 40) + 64'd155) / 64'd156),
    33'(((64'd1 << 39) + 64'd109) / 64'd110),
    33'(((64'd1 << 39) + 64'd71) / 64'd72),
    33'(((64'd1 << 38) + 64'd41) / 64'd42),
    33'(((64'd1 << 37) + 64'd19) / 64'd20),
    33'(((64'd1 << 35) + 64'd5) / 64'd6)
  };
  localparam logic [5:0] TAYLOR_SHIFT [6] = '{6'd40, 6'd39, 6'd39, 6'd38, 6'd37, 6'd35};

  typedef enum logic [1:0] {
    CFG_RADIUS = 2'd0,
    CFG_STACKS = 2'd1,
    CFG_SLICES = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic [16:0] pos_z;
    logic [15:0] nrm_x;
    logic [15:0] nrm_y;
    logic [15:0] nrm_z;
    logic [16:0] tex_s;
    logic [16:0] tex_t;
    logic        strip_end;
    logic        sphere_end;
    logic        last_of_run;
  } vtx_t;

endpackage

// ===== design/uvst_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere tessellator divider
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module uvst_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic [uvst_pkg::DIV_W-1:0]     dividend,
  input  logic [uvst_pkg::DIVR_W-1:0]    divisor,
  output logic                           done,
  output logic [uvst_pkg::DIV_W-1:0]     quotient
);

  localparam int CW = $clog2(uvst_pkg::DIV_W + 1);

  logic                          busy;
  logic [CW-1:0]                 cnt;
  logic [uvst_pkg::DIVR_W-1:0]   rem;
  logic [uvst_pkg::DIVR_W-1:0]   dsr;
  logic [uvst_pkg::DIVR_W:0]     trial;
  logic [uvst_pkg::DIVR_W:0]     diff;
  logic                          ge;

  always_comb begin
    trial = {rem, quotient[uvst_pkg::DIV_W-1]};
    diff  = trial - {1'b0, dsr};
    ge    = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CW'(uvst_pkg::DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[uvst_pkg::DIV_W-2:0], ge};
      rem      <= ge ? diff[uvst_pkg::DIVR_W-1:0] : trial[uvst_pkg::DIVR_W-1:0];
    end
  end

endmodule

// ===== design/uvst_trig.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere tessellator sine unit
// Evaluates the fixed-point sine of a Q0.32 turn phase with a truncating
// Taylor series on one shared multiplier.
// ----------------------------------------------------------------------------
module uvst_trig #(
  parameter int FRAC = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  logic [31:0]            phase,
  output logic                   done,
  output logic signed [FRAC+1:0] value
);

  localparam int NW = FRAC + 2;

  logic        busy;
  logic        cap;
  logic [3:0]  op;
  logic [30:0] u;
  logic [30:0] a;
  logic [30:0] t;
  logic [31:0] a2;
  logic [31:0] p;
  logic        neg;
  logic [65:0] prod;
  logic [32:0] mul_a;
  logic [32:0] mul_b;
  logic [2:0]  k;
  logic [65:0] qd;
  logic [31:0] s;
  logic [31:0] r;
  logic [31:0] rc;

  always_comb begin
    k = ((op[3:1] == 3'd0) || (op[3:1] == 3'd7)) ? 3'd0 : 3'(op[3:1] - 3'd1);
    mul_a = '0;
    mul_b = '0;
    if (op == 4'd0) begin
      mul_a = 33'(u);
      mul_b = 33'(uvst_pkg::HALF_PI_Q30);
    end else if (op == 4'd1) begin
      mul_a = 33'(a);
      mul_b = 33'(a);
    end else if (op == 4'd14) begin
      mul_a = 33'(a);
      mul_b = 33'(t);
    end else if (!op[0]) begin
      mul_a = 33'(a2);
      mul_b = 33'(t);
    end else begin
      mul_a = 33'(p);
      mul_b = uvst_pkg::TAYLOR_RECIP[k];
    end
    qd = prod >> uvst_pkg::TAYLOR_SHIFT[k];
    s  = prod[61:30];
    r  = (s + (32'd1 << (29 - FRAC))) >> (30 - FRAC);
    rc = (r > (32'd1 << FRAC)) ? (32'd1 << FRAC) : r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cap  <= 1'b0;
      op   <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cap  <= 1'b0;
        op   <= '0;
      end else if (busy) begin
        cap <= !cap;
        if (cap) begin
          op <= op + 1'b1;
          if (op == 4'd14) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      neg <= phase[31];
      u   <= phase[30] ? 31'(uvst_pkg::Q30_ONE - 31'(phase[29:0])) : 31'(phase[29:0]);
      t   <= uvst_pkg::Q30_ONE;
    end else if (busy) begin
      if (!cap) begin
        prod <= mul_a * mul_b;
      end else if (op == 4'd0) begin
        a <= prod[60:30];
      end else if (op == 4'd1) begin
        a2 <= prod[61:30];
      end else if (op == 4'd14) begin
        value <= neg ? -NW'(rc) : NW'(rc);
      end else if (!op[0]) begin
        p <= prod[61:30];
      end else begin
        t <= 31'(uvst_pkg::Q30_ONE - 31'(qd));
      end
    end
  end

endmodule

// ===== design/uv_sphere_tessellator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere tessellator core
// Emits a latitude-longitude sphere as quad strips, two vertices per advance.
//
// The input channel carries one restart bit per transfer. A restart transfer
// starts a new sphere at the pole and produces nothing; an advance transfer
// produces the upper vertex (from the previous-ring cache) and then the lower
// vertex on the output channel. Both channels use valid and stall.
// The user must make register writes on the configuration port only while
// the core is idle; the core does not enforce this. cfg_ready is always high.
// An advance runs four 44-step divisions in the serial divider and four sine
// evaluations of 15 products on the shared multiplier, then eight products
// for normals and positions.
// A finished vertex pair waits in a two-entry output buffer while the next
// item is taken; if the receiver stalls, the core holds before writing its
// next pair until the buffer has drained.
// Reset restores radius 256, 16 stacks and 16 slices and leaves the core
// inactive until a restart transfer arrives.
// ----------------------------------------------------------------------------
module uv_sphere_tessellator_core #(
  parameter int MAX_SLICES     = 128,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] pos_x,
  output logic [16:0] pos_y,
  output logic [16:0] pos_z,
  output logic [15:0] nrm_x,
  output logic [15:0] nrm_y,
  output logic [15:0] nrm_z,
  output logic [16:0] tex_s,
  output logic [16:0] tex_t,
  output logic        strip_end,
  output logic        sphere_end,
  output logic        last_of_run
);

  localparam int F     = TRIG_FRAC_BITS;
  localparam int NW    = F + 2;
  localparam int DEPTH = MAX_SLICES + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = (F + 1 > 16) ? F + 1 : 16;

  typedef enum logic [3:0] {
    S_IDLE, S_DTH, S_DRHO, S_DTU, S_DTL, S_SR, S_CR, S_ST, S_CT,
    S_NX, S_NXC, S_NZ, S_NZC, S_POS, S_POSC, S_OUT
  } state_t;

  state_t state;

  logic [15:0] sphere_radius;
  logic [11:0] stack_count;
  logic [7:0]  slice_count;

  logic [11:0]   ring_index;
  logic [AW-1:0] slice_index;
  logic          active;
  logic [DEPTH-1:0] cache_vld;
  logic [3*NW-1:0]  cache_mem [DEPTH];
  logic [3*NW-1:0]  cache_q;
  logic             cache_vq;

  logic [11:0]   ii;
  logic [AW-1:0] jj;
  logic          div_go;
  logic          trig_go;
  logic [2:0]    pidx;
  logic [1:0]    obuf_n;

  logic [32:0] th_q;
  logic [31:0] rho_ph;
  logic [16:0] t_up;
  logic [16:0] t_lo;
  logic signed [NW-1:0] sr, cr, st, ct, nx, nz;
  logic [16:0] posv [6];
  logic [2*MW-1:0] tprod;
  uvst_pkg::vtx_t ob_up, ob_lo, cur;

  logic [11:0]   s_eff;
  logic [11:0]   sm1;
  logic [AW-1:0] n_eff;
  logic [11:0]   i_cur;
  logic [AW-1:0] j_cur;
  logic          rd_en;
  logic          wr_en;
  logic          se;
  logic          sp;

  logic [uvst_pkg::DIV_W-1:0]  div_dividend;
  logic [uvst_pkg::DIVR_W-1:0] div_divisor;
  logic                        div_done;
  logic [uvst_pkg::DIV_W-1:0]  div_q;
  logic [31:0]                 trig_phase;
  logic                        trig_done;
  logic signed [NW-1:0]        trig_val;

  logic signed [NW-1:0] up_x, up_y, up_z, nsel;
  logic [NW-1:0]   mag_a, mag_b;
  logic [MW-1:0]   tma, tmb;
  logic            mneg;
  logic [2*MW-1:0] mr;
  logic [2*MW-1:0] posmag;
  logic [16:0]     pos_val;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= 16'd256;
      stack_count   <= 12'd16;
      slice_count   <= 8'd16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        uvst_pkg::CFG_RADIUS: sphere_radius <= cfg_data;
        uvst_pkg::CFG_STACKS: stack_count   <= cfg_data[11:0];
        uvst_pkg::CFG_SLICES: slice_count   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s_eff = (stack_count < 12'd3) ? 12'd3 : stack_count;
    sm1   = s_eff - 12'd1;
    if (slice_count < 8'd4) begin
      n_eff = AW'(4);
    end else if (32'(slice_count) > 32'(MAX_SLICES)) begin
      n_eff = AW'(MAX_SLICES);
    end else begin
      n_eff = AW'(slice_count);
    end
    if (ring_index > sm1) begin
      i_cur = sm1;
    end else if (ring_index < 12'd1) begin
      i_cur = 12'd1;
    end else begin
      i_cur = ring_index;
    end
    j_cur = (slice_index > n_eff) ? n_eff : slice_index;
    se    = (jj == n_eff);
    sp    = se && (ii == sm1);
  end

  assign in_stall = (state != S_IDLE);
  assign rd_en    = (state == S_IDLE) && in_valid && !restart && active;
  assign wr_en    = (state == S_OUT) && (obuf_n == 2'd0);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cache_q <= cache_mem[j_cur];
    end
    if (wr_en) begin
      cache_mem[jj] <= {nx, cr, nz};
    end
  end

  always_comb begin
    up_x = cache_vq ? cache_q[3*NW-1:2*NW] : '0;
    up_y = cache_vq ? cache_q[2*NW-1:NW] : NW'(1 << F);
    up_z = cache_vq ? cache_q[NW-1:0] : '0;
  end

  always_comb begin
    div_dividend = '0;
    div_divisor  = '0;
    trig_phase   = '0;
    unique case (state)
      S_DTH: begin
        div_dividend = uvst_pkg::DIV_W'(jj) << 32;
        div_divisor  = uvst_pkg::DIVR_W'(n_eff);
      end
      S_DRHO: begin
        div_dividend = uvst_pkg::DIV_W'(ii) << 31;
        div_divisor  = sm1;
      end
      S_DTU: begin
        div_dividend = uvst_pkg::DIV_W'(s_eff - ii) << 16;
        div_divisor  = sm1;
      end
      S_DTL: begin
        div_dividend = uvst_pkg::DIV_W'(sm1 - ii) << 16;
        div_divisor  = sm1;
      end
      S_SR: trig_phase = rho_ph;
      S_CR: trig_phase = rho_ph + uvst_pkg::QUARTER_TURN;
      S_ST: trig_phase = th_q[31:0];
      S_CT: trig_phase = th_q[31:0] + uvst_pkg::QUARTER_TURN;
      default: ;
    endcase
  end

  uvst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  uvst_trig #(
    .FRAC (F)
  ) u_trig (
    .clk   (clk),
    .rst   (rst),
    .go    (trig_go),
    .phase (trig_phase),
    .done  (trig_done),
    .value (trig_val)
  );

  always_comb begin
    unique case (pidx)
      3'd0:    nsel = up_x;
      3'd1:    nsel = up_y;
      3'd2:    nsel = up_z;
      3'd3:    nsel = nx;
      3'd4:    nsel = cr;
      3'd5:    nsel = nz;
      default: nsel = '0;
    endcase
    if (state == S_NZ || state == S_NZC) begin
      mag_a = st[NW-1] ? NW'(-st) : NW'(st);
      mneg  = !(st[NW-1] ^ sr[NW-1]);
    end else begin
      mag_a = ct[NW-1] ? NW'(-ct) : NW'(ct);
      mneg  = ct[NW-1] ^ sr[NW-1];
    end
    mag_b = sr[NW-1] ? NW'(-sr) : NW'(sr);
    if (state == S_POS) begin
      tma = MW'(sphere_radius);
      tmb = nsel[NW-1] ? MW'(NW'(-nsel)) : MW'(NW'(nsel));
    end else begin
      tma = MW'(mag_a);
      tmb = MW'(mag_b);
    end
    mr     = (tprod + ((2*MW)'(1) << (F - 1))) >> F;
    posmag = nsel[NW-1] ? ((tprod + (((2*MW)'(1) << F) - (2*MW)'(1))) >> F)
                        : (tprod >> F);
    pos_val = nsel[NW-1] ? 17'(-posmag) : 17'(posmag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ring_index  <= '0;
      slice_index <= '0;
      active      <= 1'b0;
      cache_vld   <= '0;
      cache_vq    <= 1'b0;
      div_go      <= 1'b0;
      trig_go     <= 1'b0;
      pidx        <= '0;
      obuf_n      <= '0;
    end else begin
      div_go  <= 1'b0;
      trig_go <= 1'b0;
      if (out_valid && !out_stall) begin
        obuf_n <= obuf_n - 2'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (restart) begin
              ring_index  <= 12'd1;
              slice_index <= '0;
              active      <= 1'b1;
              cache_vld   <= '0;
            end else if (active) begin
              ii       <= i_cur;
              jj       <= j_cur;
              cache_vq <= cache_vld[j_cur];
              div_go   <= 1'b1;
              state    <= S_DTH;
            end
          end
        end
        S_DTH: begin
          if (div_done) begin
            th_q   <= div_q[32:0];
            div_go <= 1'b1;
            state  <= S_DRHO;
          end
        end
        S_DRHO: begin
          if (div_done) begin
            rho_ph <= div_q[31:0];
            div_go <= 1'b1;
            state  <= S_DTU;
          end
        end
        S_DTU: begin
          if (div_done) begin
            t_up   <= div_q[16:0];
            div_go <= 1'b1;
            state  <= S_DTL;
          end
        end
        S_DTL: begin
          if (div_done) begin
            t_lo    <= div_q[16:0];
            trig_go <= 1'b1;
            state   <= S_SR;
          end
        end
        S_SR: begin
          if (trig_done) begin
            sr      <= trig_val;
            trig_go <= 1'b1;
            state   <= S_CR;
          end
        end
        S_CR: begin
          if (trig_done) begin
            cr      <= trig_val;
            trig_go <= 1'b1;
            state   <= S_ST;
          end
        end
        S_ST: begin
          if (trig_done) begin
            st      <= trig_val;
            trig_go <= 1'b1;
            state   <= S_CT;
          end
        end
        S_CT: begin
          if (trig_done) begin
            ct    <= trig_val;
            state <= S_NX;
          end
        end
        S_NX: begin
          tprod <= tma * tmb;
          state <= S_NXC;
        end
        S_NXC: begin
          nx    <= mneg ? -NW'(mr) : NW'(mr);
          state <= S_NZ;
        end
        S_NZ: begin
          tprod <= tma * tmb;
          state <= S_NZC;
        end
        S_NZC: begin
          nz    <= mneg ? -NW'(mr) : NW'(mr);
          pidx  <= '0;
          state <= S_POS;
        end
        S_POS: begin
          tprod <= tma * tmb;
          state <= S_POSC;
        end
        S_POSC: begin
          posv[pidx] <= pos_val;
          if (pidx == 3'd5) begin
            state <= S_OUT;
          end else begin
            pidx  <= pidx + 3'd1;
            state <= S_POS;
          end
        end
        S_OUT: begin
          if (obuf_n == 2'd0) begin
            ob_up.pos_x       <= posv[0];
            ob_up.pos_y       <= posv[1];
            ob_up.pos_z       <= posv[2];
            ob_up.nrm_x       <= 16'(up_x);
            ob_up.nrm_y       <= 16'(up_y);
            ob_up.nrm_z       <= 16'(up_z);
            ob_up.tex_s       <= th_q[32:16];
            ob_up.tex_t       <= t_up;
            ob_up.strip_end   <= 1'b0;
            ob_up.sphere_end  <= 1'b0;
            ob_up.last_of_run <= 1'b0;
            ob_lo.pos_x       <= posv[3];
            ob_lo.pos_y       <= posv[4];
            ob_lo.pos_z       <= posv[5];
            ob_lo.nrm_x       <= 16'(nx);
            ob_lo.nrm_y       <= 16'(cr);
            ob_lo.nrm_z       <= 16'(nz);
            ob_lo.tex_s       <= th_q[32:16];
            ob_lo.tex_t       <= t_lo;
            ob_lo.strip_end   <= se;
            ob_lo.sphere_end  <= sp;
            ob_lo.last_of_run <= 1'b1;
            obuf_n            <= 2'd2;
            cache_vld[jj]     <= 1'b1;
            if (se) begin
              slice_index <= '0;
              if (sp) begin
                active <= 1'b0;
              end else begin
                ring_index <= ii + 12'd1;
              end
            end else begin
              slice_index <= jj + AW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cur         = (obuf_n == 2'd2) ? ob_up : ob_lo;
  assign out_valid   = (obuf_n != 2'd0);
  assign pos_x       = cur.pos_x;
  assign pos_y       = cur.pos_y;
  assign pos_z       = cur.pos_z;
  assign nrm_x       = cur.nrm_x;
  assign nrm_y       = cur.nrm_y;
  assign nrm_z       = cur.nrm_z;
  assign tex_s       = cur.tex_s;
  assign tex_t       = cur.tex_t;
  assign strip_end   = cur.strip_end;
  assign sphere_end  = cur.sphere_end;
  assign last_of_run = cur.last_of_run;

  a_restart_state: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && restart) |=>
      (active && ring_index == 12'd1 && slice_index == '0))
    else $error("restart did not reset the ring walk");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DTH || state == S_DRHO || state == S_DTU || state == S_DTL))
    else $error("divider finished outside a division step");

  a_trig_done_state: assert property (@(posedge clk) disable iff (rst)
    trig_done |-> (state == S_SR || state == S_CR || state == S_ST || state == S_CT))
    else $error("sine unit finished outside a sine step");

  a_obuf_bound: assert property (@(posedge clk) disable iff (rst)
    obuf_n != 2'd3)
    else $error("output buffer holds more than one vertex pair");

  a_cache_marked: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> cache_vld[$past(jj)])
    else $error("cache entry written without its valid bit");

endmodule
